// ----- hdl/paik_pkg.sv -----
// Shared types and constants for the planar arm inverse kinematics block.
// No dependencies; used by paik_ctrl, paik_dp and planar_arm_ik_step.
package paik_pkg;

  localparam int unsigned LenW    = 14;
  localparam int unsigned CfgIdxW = 4;

  // Register reset values, unsigned Q6.8
  localparam logic [LenW-1:0] Link1Rst   = 14'd2560;
  localparam logic [LenW-1:0] Link2Rst   = 14'd3072;
  localparam logic [LenW-1:0] Link3Rst   = 14'd2048;
  localparam logic [LenW-1:0] MaxStepRst = 14'd512;

  // Quarter-wave sine polynomial, Q16
  localparam logic [17:0] SinK1 = 18'd205887;
  localparam logic [16:0] SinK2 = 17'd84094;
  localparam logic [13:0] SinK3 = 14'd9279;

  // 2^28 / (2*pi)
  localparam logic [25:0] InvTwoPiQ28 = 26'd42722830;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINK1    = 4'd0,
    REG_LINK2    = 4'd1,
    REG_LINK3    = 4'd2,
    REG_MAX_STEP = 4'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_TRIG_U,
    OP_TRIG_U2,
    OP_TRIG_IN,
    OP_TRIG_MID,
    OP_TRIG_S,
    OP_TRIG_ACC,
    OP_TIP,
    OP_LEN,
    OP_SQRT,
    OP_LIM_INIT,
    OP_DIV,
    OP_LIM_DONE,
    OP_NORM,
    OP_JAC,
    OP_MACC,
    OP_DET1,
    OP_DET2,
    OP_W1,
    OP_W2,
    OP_NUM1,
    OP_NUM2,
    OP_DINIT,
    OP_APPLY,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic over;
    logic norm_big;
    logic det_pos;
  } status_t;

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        joint_angle_a;
    logic [15:0]        joint_angle_b;
    logic [15:0]        joint_angle_c;
    logic signed [15:0] tip_x;
    logic signed [15:0] tip_y;
    logic               singular;
  } out_item_t;

endpackage

// ----- hdl/paik_ctrl.sv -----
// Sequencer for the inverse kinematics step: issues one datapath command per cycle, OP_NONE while idle or stalled.
// Depends on paik_pkg.
module paik_ctrl #(
  parameter int unsigned AngleBits = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  paik_pkg::status_t status_i,
  output paik_pkg::cmd_t    cmd_o
);

  localparam int unsigned DivSteps = AngleBits + 12;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_TRIG  = 23'h000002,
    S_TIP   = 23'h000004,
    S_LEN   = 23'h000008,
    S_CHK   = 23'h000010,
    S_SQRT  = 23'h000020,
    S_LINIT = 23'h000040,
    S_LDIV  = 23'h000080,
    S_LDONE = 23'h000100,
    S_NORM  = 23'h000200,
    S_JAC   = 23'h000400,
    S_MACC  = 23'h000800,
    S_DET1  = 23'h001000,
    S_DET2  = 23'h002000,
    S_DCHK  = 23'h004000,
    S_W1    = 23'h008000,
    S_W2    = 23'h010000,
    S_NUM1  = 23'h020000,
    S_NUM2  = 23'h040000,
    S_DINIT = 23'h080000,
    S_DDIV  = 23'h100000,
    S_APPLY = 23'h200000,
    S_OUT   = 23'h400000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [2:0] sel_q, sel_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = paik_pkg::OP_NONE;
    cmd_o.sel   = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = paik_pkg::OP_LOAD;
          state_d  = S_TRIG;
          cnt_d    = '0;
          sel_d    = '0;
        end
      end
      S_TRIG: begin
        unique case (cnt_q[2:0])
          3'd0:    cmd_o.op = paik_pkg::OP_TRIG_U;
          3'd1:    cmd_o.op = paik_pkg::OP_TRIG_U2;
          3'd2:    cmd_o.op = paik_pkg::OP_TRIG_IN;
          3'd3:    cmd_o.op = paik_pkg::OP_TRIG_MID;
          3'd4:    cmd_o.op = paik_pkg::OP_TRIG_S;
          default: cmd_o.op = paik_pkg::OP_TRIG_ACC;
        endcase
        if (cnt_q == 6'd5) begin
          cnt_d = '0;
          if (sel_q == 3'd5) begin
            state_d = S_TIP;
          end else begin
            sel_d = sel_q + 3'd1;
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_TIP: begin
        cmd_o.op = paik_pkg::OP_TIP;
        state_d  = S_LEN;
      end
      S_LEN: begin
        cmd_o.op = paik_pkg::OP_LEN;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cnt_d   = '0;
        state_d = status_i.over ? S_SQRT : S_NORM;
      end
      S_SQRT: begin
        cmd_o.op = paik_pkg::OP_SQRT;
        if (cnt_q == 6'd16) begin
          state_d = S_LINIT;
          sel_d   = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_LINIT: begin
        cmd_o.op = paik_pkg::OP_LIM_INIT;
        cnt_d    = '0;
        state_d  = S_LDIV;
      end
      S_LDIV: begin
        cmd_o.op = paik_pkg::OP_DIV;
        if (cnt_q == 6'd30) begin
          state_d = S_LDONE;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_LDONE: begin
        cmd_o.op = paik_pkg::OP_LIM_DONE;
        if (sel_q[0]) begin
          state_d = S_NORM;
        end else begin
          sel_d   = 3'd1;
          state_d = S_LINIT;
        end
      end
      S_NORM: begin
        if (status_i.norm_big) begin
          cmd_o.op = paik_pkg::OP_NORM;
        end else begin
          state_d = S_JAC;
        end
      end
      S_JAC: begin
        cmd_o.op = paik_pkg::OP_JAC;
        sel_d    = '0;
        state_d  = S_MACC;
      end
      S_MACC: begin
        cmd_o.op = paik_pkg::OP_MACC;
        if (sel_q == 3'd2) begin
          state_d = S_DET1;
        end else begin
          sel_d = sel_q + 3'd1;
        end
      end
      S_DET1: begin
        cmd_o.op = paik_pkg::OP_DET1;
        state_d  = S_DET2;
      end
      S_DET2: begin
        cmd_o.op = paik_pkg::OP_DET2;
        state_d  = S_DCHK;
      end
      S_DCHK: begin
        state_d = status_i.det_pos ? S_W1 : S_OUT;
      end
      S_W1: begin
        cmd_o.op = paik_pkg::OP_W1;
        state_d  = S_W2;
      end
      S_W2: begin
        cmd_o.op = paik_pkg::OP_W2;
        sel_d    = '0;
        state_d  = S_NUM1;
      end
      S_NUM1: begin
        cmd_o.op = paik_pkg::OP_NUM1;
        state_d  = S_NUM2;
      end
      S_NUM2: begin
        cmd_o.op = paik_pkg::OP_NUM2;
        state_d  = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = paik_pkg::OP_DINIT;
        cnt_d    = '0;
        state_d  = S_DDIV;
      end
      S_DDIV: begin
        cmd_o.op = paik_pkg::OP_DIV;
        if (cnt_q == 6'(DivSteps - 1)) begin
          state_d = S_APPLY;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_APPLY: begin
        cmd_o.op = paik_pkg::OP_APPLY;
        if (sel_q == 3'd2) begin
          state_d = S_OUT;
        end else begin
          sel_d   = sel_q + 3'd1;
          state_d = S_NUM1;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = paik_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/paik_dp.sv -----
// Datapath for the inverse kinematics step: trig, step limit, Jacobian,
// shared serial divider, joint state and result register. Depends on paik_pkg.
module paik_dp #(
  parameter int unsigned AngleBits = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  paik_pkg::cmd_t                cmd_i,
  output paik_pkg::status_t             status_o,
  input  paik_pkg::in_item_t            in_item_i,
  input  logic                          cfg_we_i,
  input  logic [paik_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [paik_pkg::LenW-1:0]     cfg_data_i,
  output paik_pkg::out_item_t           out_item_o
);

  localparam int unsigned DivSteps = AngleBits + 12;
  localparam int unsigned LowW     = (DivSteps > 31) ? DivSteps : 31;
  localparam int unsigned NwW      = 60 + 22 + AngleBits;
  localparam logic [AngleBits-1:0] AngRstA = AngleBits'(((1 << AngleBits) + 6) / 12);
  localparam logic [AngleBits-1:0] AngRstB = AngleBits'(((1 << AngleBits) + 1) / 3);
  localparam logic [AngleBits-1:0] QuarterTurn = {2'b01, {(AngleBits-2){1'b0}}};
  localparam logic [DivSteps-1:0]  QCap = {1'b1, {(DivSteps-1){1'b0}}};
  localparam logic [AngleBits-1:0] DCap = {1'b0, {(AngleBits-1){1'b1}}};

  function automatic logic [30:0] mag31(logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    mag31 = v[31] ? n[30:0] : v[30:0];
  endfunction

  function automatic logic [15:0] out16(logic [AngleBits-1:0] a);
    logic [AngleBits+15:0] t;
    t = {a, 16'd0};
    out16 = t[AngleBits+15 -: 16];
  endfunction

  // configuration and joint state
  logic [paik_pkg::LenW-1:0] link1_q, link2_q, link3_q, max_step_q;
  logic [AngleBits-1:0]      ang_a_q, ang_b_q, ang_c_q;

  // payload registers
  logic signed [15:0] gx_q, gy_q, tx_q, ty_q;
  logic [16:0]        uu_q, u2_q, inner_q;
  logic [17:0]        mid_q;
  logic               neg_q;
  logic signed [15:0] s_q;
  logic signed [31:0] x_q [3];
  logic signed [31:0] y_q [3];
  logic signed [17:0] ex_q, ey_q;
  logic [33:0]        len2_q, sv_q, rs_q;
  logic [4:0]         bp_q;
  logic [30:0]        orv_q;
  logic [4:0]         k_q;
  logic signed [13:0] j0_q [3];
  logic signed [13:0] j1_q [3];
  logic signed [29:0] m00_q, m01_q, m11_q;
  logic signed [59:0] pdet_q, det_q;
  logic               sing_q;
  logic signed [47:0] w0_q, w1_q;
  logic signed [61:0] num_q;
  logic [59:0]        rem_q, den_q;
  logic [LowW-1:0]    low_q, q_q;
  logic               sat_q;
  paik_pkg::out_item_t out_q;

  // combinational helpers
  logic [1:0]              g;
  logic [1:0]              ix;
  logic [AngleBits-1:0]    base, ph;
  logic [31:0]             pw;
  logic [15:0]             u16;
  logic [16:0]             uu_d;
  logic [33:0]             t_u2;
  logic [30:0]             t_in;
  logic [33:0]             t_mid;
  logic [34:0]             t_s;
  logic [15:0]             s_mag;
  logic [paik_pkg::LenW-1:0] lnk;
  logic signed [31:0]      acc_prod, acc_prev, acc_sum;
  logic signed [31:0]      x0s, y0s;
  logic signed [15:0]      tx_d, ty_d;
  logic signed [17:0]      ex_d, ey_d;
  logic signed [36:0]      len2_w;
  logic [27:0]             ms_sq;
  logic [33:0]             bitv, trial;
  logic signed [17:0]      lim_e;
  logic [16:0]             lim_mag;
  logic [30:0]             lim_prod;
  logic signed [17:0]      lim_q;
  logic [60:0]             rem2;
  logic                    ge;
  logic [60:0]             rem_sub;
  logic signed [29:0]      p00, p01, p11;
  logic signed [59:0]      det_d, m01_sq;
  logic signed [47:0]      w0_sub, w1_sub;
  logic signed [61:0]      prod_n0, prod_n1, nmag_s;
  logic [5:0]              sh;
  logic [NwW-1:0]          nw;
  logic [NwW-DivSteps-1:0] rem0;
  logic [DivSteps-1:0]     qf;
  logic [DivSteps+25:0]    dprod;
  logic [AngleBits+1:0]    dd;
  logic [AngleBits-1:0]    ddc, ang_sel, ang_new;

  always_comb begin
    g    = cmd_i.sel[2:1];
    ix   = cmd_i.sel[1:0];
    base = (g == 2'd0) ? (ang_a_q + ang_b_q + ang_c_q)
         : (g == 2'd1) ? (ang_a_q + ang_b_q) : ang_a_q;
    // even select codes are cosines: a quarter turn ahead
    ph   = base + (cmd_i.sel[0] ? '0 : QuarterTurn);
    pw   = {ph, {(32-AngleBits){1'b0}}};
    u16  = pw[29:14];
    uu_d = ph[AngleBits-2] ? (17'd65536 - {1'b0, u16}) : {1'b0, u16};

    t_u2  = uu_q * uu_q;
    t_in  = u2_q * paik_pkg::SinK3;
    t_mid = u2_q * inner_q;
    t_s   = uu_q * mid_q;
    s_mag = t_s[34:19];

    lnk      = (g == 2'd0) ? link3_q : (g == 2'd1) ? link2_q : link1_q;
    acc_prod = $signed({1'b0, lnk}) * s_q;
    if (cmd_i.sel[0]) begin
      acc_prev = (g == 2'd0) ? 32'sd0 : (g == 2'd1) ? y_q[2] : y_q[1];
    end else begin
      acc_prev = (g == 2'd0) ? 32'sd0 : (g == 2'd1) ? x_q[2] : x_q[1];
    end
    acc_sum = acc_prod + acc_prev;

    // tip, floor shift then saturate
    x0s = x_q[0] >>> 14;
    y0s = y_q[0] >>> 14;
    priority if (x0s > 32'sd32767)  tx_d = 16'sd32767;
    else if (x0s < -32'sd32768)     tx_d = -16'sd32768;
    else                            tx_d = x0s[15:0];
    priority if (y0s > 32'sd32767)  ty_d = 16'sd32767;
    else if (y0s < -32'sd32768)     ty_d = -16'sd32768;
    else                            ty_d = y0s[15:0];
    ex_d = gx_q - tx_d;
    ey_d = gy_q - ty_d;

    len2_w = ex_q * ex_q + ey_q * ey_q;
    ms_sq  = max_step_q * max_step_q;

    bitv  = 34'd1 << {bp_q, 1'b0};
    trial = rs_q + bitv;

    lim_e    = cmd_i.sel[0] ? ey_q : ex_q;
    lim_mag  = lim_e[17] ? 17'(-lim_e) : lim_e[16:0];
    lim_prod = lim_mag * max_step_q;
    lim_q    = lim_e[17] ? -$signed({4'd0, q_q[13:0]}) : $signed({4'd0, q_q[13:0]});

    rem2    = {rem_q, low_q[LowW-1]};
    ge      = (rem2 >= {1'b0, den_q});
    rem_sub = rem2 - {1'b0, den_q};

    p00 = j0_q[ix] * j0_q[ix];
    p01 = j0_q[ix] * j1_q[ix];
    p11 = j1_q[ix] * j1_q[ix];

    m01_sq = m01_q * m01_q;
    det_d  = pdet_q - m01_sq;

    w0_sub = m01_q * ey_q;
    w1_sub = m01_q * ex_q;

    prod_n0 = j0_q[ix] * w0_q;
    prod_n1 = j1_q[ix] * w1_q;

    nmag_s = num_q[61] ? -num_q : num_q;
    sh     = 6'(22 + AngleBits) - {1'b0, k_q};
    nw     = NwW'(nmag_s[59:0]) << sh;
    rem0   = nw[NwW-1:DivSteps];

    qf    = (sat_q || (q_q[DivSteps-1:0] >= QCap)) ? QCap : q_q[DivSteps-1:0];
    dprod = qf * paik_pkg::InvTwoPiQ28;
    dd    = dprod[DivSteps+25:36];
    ddc   = (dd > {2'b00, DCap}) ? DCap : dd[AngleBits-1:0];

    ang_sel = (ix == 2'd0) ? ang_a_q : (ix == 2'd1) ? ang_b_q : ang_c_q;
    ang_new = num_q[61] ? (ang_sel - ddc) : (ang_sel + ddc);
  end

  assign status_o.over     = (len2_q > 34'(ms_sq));
  assign status_o.norm_big = (orv_q[30:13] != '0);
  assign status_o.det_pos  = (det_q > 60'sd0);
  assign out_item_o        = out_q;

  // configuration and joint state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link1_q    <= paik_pkg::Link1Rst;
      link2_q    <= paik_pkg::Link2Rst;
      link3_q    <= paik_pkg::Link3Rst;
      max_step_q <= paik_pkg::MaxStepRst;
      ang_a_q    <= AngRstA;
      ang_b_q    <= AngRstB;
      ang_c_q    <= AngRstA;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          paik_pkg::REG_LINK1:    link1_q    <= cfg_data_i;
          paik_pkg::REG_LINK2:    link2_q    <= cfg_data_i;
          paik_pkg::REG_LINK3:    link3_q    <= cfg_data_i;
          paik_pkg::REG_MAX_STEP: max_step_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == paik_pkg::OP_APPLY) begin
        unique case (ix)
          2'd0:    ang_a_q <= ang_new;
          2'd1:    ang_b_q <= ang_new;
          default: ang_c_q <= ang_new;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      paik_pkg::OP_LOAD: begin
        gx_q <= in_item_i.goal_x;
        gy_q <= in_item_i.goal_y;
      end
      paik_pkg::OP_TRIG_U: begin
        uu_q  <= uu_d;
        neg_q <= ph[AngleBits-1];
      end
      paik_pkg::OP_TRIG_U2:  u2_q    <= t_u2[32:16];
      paik_pkg::OP_TRIG_IN:  inner_q <= paik_pkg::SinK2 - {2'b00, t_in[30:16]};
      paik_pkg::OP_TRIG_MID: mid_q   <= paik_pkg::SinK1 - t_mid[33:16];
      paik_pkg::OP_TRIG_S:   s_q     <= neg_q ? -$signed(s_mag) : $signed(s_mag);
      paik_pkg::OP_TRIG_ACC: begin
        if (cmd_i.sel[0]) begin
          y_q[2'd2 - g] <= acc_sum;
        end else begin
          x_q[2'd2 - g] <= acc_sum;
        end
      end
      paik_pkg::OP_TIP: begin
        tx_q  <= tx_d;
        ty_q  <= ty_d;
        ex_q  <= ex_d;
        ey_q  <= ey_d;
        orv_q <= mag31(x_q[0]) | mag31(x_q[1]) | mag31(x_q[2])
               | mag31(y_q[0]) | mag31(y_q[1]) | mag31(y_q[2]);
        k_q   <= '0;
      end
      paik_pkg::OP_LEN: begin
        len2_q <= len2_w[33:0];
        sv_q   <= len2_w[33:0];
        rs_q   <= '0;
        bp_q   <= 5'd16;
      end
      paik_pkg::OP_SQRT: begin
        if (sv_q >= trial) begin
          sv_q <= sv_q - trial;
          rs_q <= (rs_q >> 1) + bitv;
        end else begin
          rs_q <= rs_q >> 1;
        end
        bp_q <= bp_q - 5'd1;
      end
      paik_pkg::OP_LIM_INIT: begin
        rem_q <= '0;
        q_q   <= '0;
        low_q <= LowW'(lim_prod) << (LowW - 31);
        den_q <= 60'(rs_q[16:0]);
      end
      paik_pkg::OP_DIV: begin
        rem_q <= ge ? rem_sub[59:0] : rem2[59:0];
        q_q   <= {q_q[LowW-2:0], ge};
        low_q <= low_q << 1;
      end
      paik_pkg::OP_LIM_DONE: begin
        if (cmd_i.sel[0]) begin
          ey_q <= lim_q;
        end else begin
          ex_q <= lim_q;
        end
      end
      paik_pkg::OP_NORM: begin
        orv_q <= orv_q >> 1;
        k_q   <= k_q + 5'd1;
      end
      paik_pkg::OP_JAC: begin
        for (int i = 0; i < 3; i++) begin
          j0_q[i] <= 14'((-y_q[i]) >>> k_q);
          j1_q[i] <= 14'(x_q[i] >>> k_q);
        end
        m00_q <= '0;
        m01_q <= '0;
        m11_q <= '0;
      end
      paik_pkg::OP_MACC: begin
        m00_q <= m00_q + p00;
        m01_q <= m01_q + p01;
        m11_q <= m11_q + p11;
      end
      paik_pkg::OP_DET1: pdet_q <= m00_q * m11_q;
      paik_pkg::OP_DET2: begin
        det_q  <= det_d;
        sing_q <= !(det_d > 60'sd0);
      end
      paik_pkg::OP_W1: begin
        w0_q <= m11_q * ex_q;
        w1_q <= m00_q * ey_q;
      end
      paik_pkg::OP_W2: begin
        w0_q <= w0_q - w0_sub;
        w1_q <= w1_q - w1_sub;
      end
      paik_pkg::OP_NUM1: num_q <= prod_n0;
      paik_pkg::OP_NUM2: num_q <= num_q + prod_n1;
      paik_pkg::OP_DINIT: begin
        sat_q <= (rem0 >= (NwW-DivSteps)'(det_q[59:0]));
        rem_q <= rem0[59:0];
        q_q   <= '0;
        low_q <= LowW'(nw[DivSteps-1:0]) << (LowW - DivSteps);
        den_q <= det_q[59:0];
      end
      paik_pkg::OP_OUT: begin
        out_q.joint_angle_a <= out16(ang_a_q);
        out_q.joint_angle_b <= out16(ang_b_q);
        out_q.joint_angle_c <= out16(ang_c_q);
        out_q.tip_x         <= tx_q;
        out_q.tip_y         <= ty_q;
        out_q.singular      <= sing_q;
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/planar_arm_ik_step.sv -----
// Planar three-link arm, one pseudo-inverse IK step per item: take the goal, compute
// sine and cosine of the three summed joint angles, run the sqrt and two divides when
// the step is limited, normalize, then derive the three angle deltas through the
// shared serial divider unless the Jacobian is singular.
// One item at a time; the next is taken once the result sits in the output register.
// Async active-low reset restores the link lengths, step limit and 30/120/30 degree pose.
module planar_arm_ik_step #(
  parameter int unsigned AngleBits = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // goal items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  paik_pkg::in_item_t            in_item_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output paik_pkg::out_item_t           out_item_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [paik_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [paik_pkg::LenW-1:0]     cfg_data_i
);

  paik_pkg::cmd_t    cmd;
  paik_pkg::status_t status;

  // registers are always writable; writes land only while idle by contract
  assign cfg_ready_o = 1'b1;

  // controller: one-hot sequencer, owns the handshakes
  paik_ctrl #(
    .AngleBits (AngleBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: trig polynomial, step limit (sqrt + divide), Jacobian products,
  // serial divider for the deltas, joint angles and the result register
  paik_dp #(
    .AngleBits (AngleBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_item_o  (out_item_o)
  );

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after taking an item");

  // a new result appears only as the block returns to idle
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result raised while still busy");

  // finishing an item always leaves a result pending
  a_idle_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("returned to idle without a result");

endmodule
